// ===== rtl/core/swbr_pkg.sv =====
// ----------------------------------------------------------------------------
// swbr_pkg
// Shared constants, types and helper functions of the sliding window block
// receiver.
// ----------------------------------------------------------------------------
package swbr_pkg;

	localparam int MAX_WINDOW      = 32;
	localparam int SEQ_SPACE_RATIO = 2;
	localparam int EOF_ACKS        = 8;

	// field widths
	localparam int SEQ_W  = 8;
	localparam int PAY_W  = 11;
	localparam int WS_W   = 6;
	localparam int BS_W   = 11;
	localparam int BLK_W  = 6;

	// derived widths
	localparam int WSC_W     = $clog2(MAX_WINDOW + 1);
	localparam int MAP_IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int REP_W     = (EOF_ACKS > 1) ? $clog2(EOF_ACKS) : 1;
	localparam int SPACE_W   = 9;
	localparam int PROD_W    = $clog2(SEQ_SPACE_RATIO * MAX_WINDOW + 1);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd1;

	localparam logic [WS_W-1:0] WS_RESET = 6'd8;
	localparam logic [BS_W-1:0] BS_RESET = 11'd1024;

	typedef struct packed {
		logic [WSC_W-1:0]   ws;
		logic [SPACE_W-1:0] space;
		logic [BS_W-1:0]    block_size;
		logic               restart;
		logic [WSC_W-1:0]   restart_ws;
	} cfg_t;

	typedef struct packed {
		logic [SEQ_W-1:0] ack_seq;
		logic             window_done;
		logic [BLK_W-1:0] blocks_in_window;
		logic [BS_W-1:0]  final_block_bytes;
		logic             end_of_file;
	} ack_word_t;

	typedef struct packed {
		logic             load;
		ack_word_t        word;
		logic [REP_W-1:0] reps;
	} ack_req_t;

	// window size used clamped to 1..MAX_WINDOW
	function automatic logic [WSC_W-1:0] clamp_ws(input logic [WS_W-1:0] w);
		logic [WSC_W-1:0] r;
		if (w == '0) begin
			r = WSC_W'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = WSC_W'(MAX_WINDOW);
		end else begin
			r = WSC_W'(w);
		end
		return r;
	endfunction

	// sequence space, capped at 256
	function automatic logic [SPACE_W-1:0] seq_space(input logic [WSC_W-1:0] ws);
		logic [PROD_W-1:0] p;
		logic [SPACE_W-1:0] r;
		p = PROD_W'(ws) * PROD_W'(SEQ_SPACE_RATIO);
		if (SPACE_W'(p) > 9'd256 || PROD_W > SPACE_W && (p >> SPACE_W) != '0) begin
			r = 9'd256;
		end else begin
			r = SPACE_W'(p);
		end
		return r;
	endfunction

	// last number of a window opened at base, cut short at 255
	function automatic logic [SEQ_W-1:0] window_last(input logic [SEQ_W-1:0] base,
			input logic [WSC_W-1:0] ws);
		logic [8:0] sum;
		logic [SEQ_W-1:0] r;
		sum = {1'b0, base} + 9'(ws);
		if (sum > 9'd256) begin
			r = 8'hFF;
		end else begin
			r = SEQ_W'(sum - 9'd1);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/swbr_if.sv =====
// ----------------------------------------------------------------------------
// swbr channel interfaces
// Valid/ready channels for received packets and acknowledgements.
// ----------------------------------------------------------------------------
interface swbr_pkt_if import swbr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] seq_num;
	logic [PAY_W-1:0] payload_bytes;

	modport source (output valid, output seq_num, output payload_bytes, input ready);
	modport sink   (input valid, input seq_num, input payload_bytes, output ready);
endinterface

interface swbr_ack_if import swbr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] ack_seq;
	logic             window_done;
	logic [BLK_W-1:0] blocks_in_window;
	logic [BS_W-1:0]  final_block_bytes;
	logic             end_of_file;
	logic             last;

	modport source (output valid, output ack_seq, output window_done,
		output blocks_in_window, output final_block_bytes, output end_of_file,
		output last, input ready);
	modport sink   (input valid, input ack_seq, input window_done,
		input blocks_in_window, input final_block_bytes, input end_of_file,
		input last, output ready);
endinterface

// ===== rtl/core/swbr_config.sv =====
// ----------------------------------------------------------------------------
// swbr_config
// Configuration registers; keeps the clamped window size and the sequence
// space ready for the window logic.
// ----------------------------------------------------------------------------
module swbr_config import swbr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	logic [WSC_W-1:0]   ws_q;
	logic [SPACE_W-1:0] space_q;
	logic [BS_W-1:0]    bs_q;
	logic               ws_wr;
	logic               bs_wr;
	logic [WSC_W-1:0]   ws_new;

	always_comb begin
		ws_wr = 1'b0;
		bs_wr = 1'b0;
		case (wr_index)
			REG_WINDOW_SIZE: ws_wr = wr_en;
			REG_BLOCK_SIZE:  bs_wr = wr_en;
			default: begin
				ws_wr = 1'b0;
				bs_wr = 1'b0;
			end
		endcase
	end

	assign ws_new = clamp_ws(wr_data[WS_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= clamp_ws(WS_RESET);
			space_q <= seq_space(clamp_ws(WS_RESET));
			bs_q    <= BS_RESET;
		end else begin
			if (ws_wr) begin
				ws_q    <= ws_new;
				space_q <= seq_space(ws_new);
			end
			if (bs_wr) begin
				bs_q <= wr_data[BS_W-1:0];
			end
		end
	end

	assign cfg.ws         = ws_q;
	assign cfg.space      = space_q;
	assign cfg.block_size = bs_q;
	assign cfg.restart    = ws_wr;
	assign cfg.restart_ws = ws_new;

endmodule

// ===== rtl/core/swbr_window.sv =====
// ----------------------------------------------------------------------------
// swbr_window
// Packet input register and window state: marks received blocks, detects
// window completion and forms the acknowledgement request.
// ----------------------------------------------------------------------------
module swbr_window import swbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	swbr_pkt_if.sink   pkt,
	input  logic       ack_free,
	output ack_req_t   req
);

	// input register
	logic             valid_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic [PAY_W-1:0] pay_s1;

	// window state
	logic [SEQ_W-1:0]      base_q;
	logic [MAX_WINDOW-1:0] map_q;
	logic [SEQ_W-1:0]      last_q;
	logic                  eof_q;
	logic [PAY_W-1:0]      eof_bytes_q;

	logic [SEQ_W-1:0]      win_last;
	logic                  in_win;
	logic [SEQ_W-1:0]      prev_seq;
	logic [SEQ_W-1:0]      off;
	logic [MAX_WINDOW-1:0] map_new;
	logic [MAX_WINDOW-1:0] need;
	logic                  is_short;
	logic [SEQ_W-1:0]      last_new;
	logic                  eof_new;
	logic [PAY_W-1:0]      eof_bytes_new;
	logic [8:0]            count;
	logic                  complete;
	logic                  has_result;
	logic                  advance;
	logic [8:0]            sum;
	logic [SEQ_W-1:0]      next_base;

	always_comb begin
		win_last = window_last(base_q, cfg.ws);
		in_win   = (seq_s1 >= base_q) && (seq_s1 <= win_last);
		prev_seq = (base_q == '0) ? SEQ_W'(cfg.space - 9'd1) : base_q - 8'd1;
		off      = seq_s1 - base_q;

		map_new = map_q;
		map_new[off[MAP_IDX_W-1:0]] = 1'b1;

		is_short      = {1'b0, pay_s1} < {1'b0, cfg.block_size};
		last_new      = is_short ? seq_s1 : last_q;
		eof_new       = is_short | eof_q;
		eof_bytes_new = is_short ? pay_s1 : eof_bytes_q;

		count = {1'b0, last_new} - {1'b0, base_q} + 9'd1;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			need[i] = 9'(i) < count;
		end
		complete   = &(map_new | ~need);
		has_result = !in_win || complete;

		// advance modulo the sequence space; base + ws stays below twice the space
		sum       = {1'b0, base_q} + 9'(cfg.ws);
		next_base = (sum >= cfg.space) ? SEQ_W'(sum - cfg.space) : SEQ_W'(sum);
		if (eof_new) begin
			next_base = '0;
		end
	end

	assign advance   = valid_s1 && (!has_result || ack_free);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			seq_s1 <= pkt.seq_num;
			pay_s1 <= pkt.payload_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			map_q       <= '0;
			last_q      <= window_last('0, clamp_ws(WS_RESET));
			eof_q       <= 1'b0;
			eof_bytes_q <= '0;
		end else if (cfg.restart) begin
			base_q      <= '0;
			map_q       <= '0;
			last_q      <= window_last('0, cfg.restart_ws);
			eof_q       <= 1'b0;
			eof_bytes_q <= '0;
		end else if (advance && in_win) begin
			if (complete) begin
				base_q      <= next_base;
				map_q       <= '0;
				last_q      <= window_last(next_base, cfg.ws);
				eof_q       <= 1'b0;
				eof_bytes_q <= '0;
			end else begin
				map_q       <= map_new;
				last_q      <= last_new;
				eof_q       <= eof_new;
				eof_bytes_q <= eof_bytes_new;
			end
		end
	end

	always_comb begin
		req.load = advance && has_result;
		if (!in_win) begin
			req.word.ack_seq           = prev_seq;
			req.word.window_done       = 1'b0;
			req.word.blocks_in_window  = '0;
			req.word.final_block_bytes = '0;
			req.word.end_of_file       = 1'b0;
			req.reps                   = '0;
		end else begin
			req.word.ack_seq           = last_new;
			req.word.window_done       = 1'b1;
			req.word.blocks_in_window  = count[BLK_W-1:0];
			req.word.final_block_bytes = eof_new ? eof_bytes_new : cfg.block_size;
			req.word.end_of_file       = eof_new;
			req.reps                   = eof_new ? REP_W'(EOF_ACKS - 1) : '0;
		end
	end

endmodule

// ===== rtl/core/swbr_ack_out.sv =====
// ----------------------------------------------------------------------------
// swbr_ack_out
// Result register; repeats the held acknowledgement word the requested
// number of times and flags the final one.
// ----------------------------------------------------------------------------
module swbr_ack_out import swbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ack_req_t    req,
	output logic        ack_free,
	swbr_ack_if.source  ack
);

	logic             valid_q;
	ack_word_t        word_q;
	logic [REP_W-1:0] reps_q;

	// free when empty or when the final word leaves now
	assign ack_free = !valid_q || (ack.ready && reps_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			reps_q  <= '0;
		end else if (req.load) begin
			valid_q <= 1'b1;
			reps_q  <= req.reps;
		end else if (valid_q && ack.ready) begin
			if (reps_q == '0) begin
				valid_q <= 1'b0;
			end else begin
				reps_q <= reps_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			word_q <= req.word;
		end
	end

	assign ack.valid             = valid_q;
	assign ack.ack_seq           = word_q.ack_seq;
	assign ack.window_done       = word_q.window_done;
	assign ack.blocks_in_window  = word_q.blocks_in_window;
	assign ack.final_block_bytes = word_q.final_block_bytes;
	assign ack.end_of_file       = word_q.end_of_file;
	assign ack.last              = (reps_q == '0);

endmodule

// ===== rtl/core/sliding_window_block_receiver.sv =====
// ----------------------------------------------------------------------------
// sliding_window_block_receiver
// Receiver side of a windowed block-acknowledge protocol.
// ----------------------------------------------------------------------------
// A packet word is taken into an input register, processed there against the
// window state, and its acknowledgements are placed in a result register,
// from which the words are offered on the ack channel. A new packet can be
// accepted every cycle while the input register is not held waiting for the
// result register. A packet that completes nothing produces no word. An
// out-of-window packet or a completed window gives one word; a window that
// ends the file gives EOF_ACKS words, which the result register sends one per
// cycle while ack.ready is high, and a further packet that needs the result
// register waits until the last of them leaves. Writing window_size returns
// the window to its reset state; block_size takes effect at once.
module sliding_window_block_receiver import swbr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	swbr_pkt_if.sink              pkt,
	swbr_ack_if.source            ack
);

	cfg_t     cfg;
	ack_req_t req;
	logic     ack_free;

	swbr_config u_config (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	swbr_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pkt      (pkt),
		.ack_free (ack_free),
		.req      (req)
	);

	swbr_ack_out u_ack_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ack_free (ack_free),
		.ack      (ack)
	);

endmodule
